@@ rtl/core/rtpjb_pkg.sv @@
// shared types, constants and codes for the rtp jitter buffer
package rtpjb_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DEF_TAG_BITS = 16;

    localparam int STAMP_W     = 32;
    localparam int IN_TAG_W    = 16;
    localparam int NOW_W       = 32;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 5;
    localparam int DELAY_W     = 16;
    localparam int RATE_W      = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 4;

    localparam int MS_PER_S    = 1000;
    localparam int RESET_DELAY = 500;
    localparam int RESET_RATE  = 8000;

    // reciprocal of ms-per-second scaled by 2^38, exact for any 32-bit dividend
    localparam int                 RECIP_W  = 29;
    localparam int                 RECIP_SH = 38;
    localparam logic [RECIP_W-1:0] RECIP_MS = RECIP_W'(274877907);

    // playout scaling widths
    localparam int Q1_W  = STAMP_W + RECIP_W - RECIP_SH;
    localparam int REM_W = $clog2(MS_PER_S);
    localparam int PLO_W = REM_W + RATE_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ     = 3'd0,
        KIND_DEQ     = 3'd1,
        KIND_EXPIRE  = 3'd2,
        KIND_CLEAR   = 3'd3,
        KIND_RESTART = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_MUTED    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTREADY = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_DONE     = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY = 2'd0,
        CFG_RATE  = 2'd1,
        CFG_MUTED = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2,
        CELL_CLEAR  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic               valid;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        t_cell_op           op;
        logic [STAMP_W-1:0] stamp;
    } t_cell_ctl;

endpackage

@@ rtl/core/rtpjb_cell.sv @@
// one slot of the sorted chain: holds a stamp and a tag, shifts to its neighbors
module rtpjb_cell #(
    parameter int TAG_BITS = rtpjb_pkg::DEF_TAG_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtpjb_pkg::t_cell_ctl i_ctl,
    input  logic [TAG_BITS-1:0]  i_new_tag,
    input  rtpjb_pkg::t_entry    i_left,
    input  logic [TAG_BITS-1:0]  i_left_tag,
    input  logic                 i_left_lt,
    input  rtpjb_pkg::t_entry    i_right,
    input  logic [TAG_BITS-1:0]  i_right_tag,
    output rtpjb_pkg::t_entry    o_entry,
    output logic [TAG_BITS-1:0]  o_tag,
    output logic                 o_lt,
    output logic                 o_eq
);
    import rtpjb_pkg::*;

    logic               r_valid, n_valid;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic [TAG_BITS-1:0] r_tag, n_tag;

    assign o_lt          = r_valid && (r_stamp < i_ctl.stamp);
    assign o_eq          = r_valid && (r_stamp == i_ctl.stamp);
    assign o_entry.valid = r_valid;
    assign o_entry.stamp = r_stamp;
    assign o_tag         = r_tag;

    always_comb begin
        n_valid = r_valid;
        n_stamp = r_stamp;
        n_tag   = r_tag;
        unique case (i_ctl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (!o_lt) begin
                    if (i_left_lt) begin
                        n_valid = 1'b1;
                        n_stamp = i_ctl.stamp;
                        n_tag   = i_new_tag;
                    end else begin
                        n_valid = i_left.valid;
                        n_stamp = i_left.stamp;
                        n_tag   = i_left_tag;
                    end
                end
            end
            CELL_POP: begin
                n_valid = i_right.valid;
                n_stamp = i_right.stamp;
                n_tag   = i_right_tag;
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
        r_tag   <= n_tag;
    end

endmodule

@@ rtl/core/rtpjb_div.sv @@
// playout scaling: late ms times rate over ms-per-second, by reciprocal multiplies
module rtpjb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rtpjb_pkg::STAMP_W-1:0] i_diff,
    input  logic [rtpjb_pkg::RATE_W-1:0]  i_rate,
    output logic                          o_done,
    output logic [rtpjb_pkg::STAMP_W-1:0] o_ticks
);
    import rtpjb_pkg::*;

    localparam int DONE_LAT = 5;
    localparam int PROD1_W  = STAMP_W + RECIP_W;
    localparam int PROD2_W  = PLO_W + RECIP_W;

    logic [DONE_LAT-1:0] r_vld, n_vld;
    logic [STAMP_W-1:0]  r_diff;
    logic [RATE_W-1:0]   r_rate;
    logic [Q1_W-1:0]     r_q1;
    logic [REM_W-1:0]    r_r1;
    logic [STAMP_W-1:0]  r_phi;
    logic [PLO_W-1:0]    r_plo;
    logic [STAMP_W-1:0]  r_ticks;

    logic [PROD1_W-1:0]  w_q1_full;
    logic [STAMP_W-1:0]  w_q1_k;
    logic [PROD2_W-1:0]  w_q2_full;

    // diff = q1 * 1000 + r1, so diff * rate / 1000 = q1 * rate + r1 * rate / 1000
    assign w_q1_full = PROD1_W'(r_diff) * PROD1_W'(RECIP_MS);
    assign w_q1_k    = STAMP_W'(r_q1) * STAMP_W'(MS_PER_S);
    assign w_q2_full = PROD2_W'(r_plo) * PROD2_W'(RECIP_MS);

    assign n_vld = {r_vld[DONE_LAT-2:0], i_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_diff <= i_diff;
            r_rate <= i_rate;
        end
        r_q1    <= w_q1_full[PROD1_W-1:RECIP_SH];
        r_r1    <= REM_W'(r_diff - w_q1_k);
        r_phi   <= STAMP_W'(r_q1) * STAMP_W'(r_rate);
        r_plo   <= PLO_W'(r_r1) * PLO_W'(r_rate);
        r_ticks <= r_phi + STAMP_W'(w_q2_full[PROD2_W-1:RECIP_SH]);
    end

    assign o_done  = r_vld[DONE_LAT-1];
    assign o_ticks = r_ticks;

endmodule

@@ rtl/core/rtp_jitter_buffer.sv @@
// top level of the rtp jitter buffer: sorted cell chain, playout target and control
//
// channel  dir  handshake             payload
// s        in   i_s_tvalid/o_s_tready tdata {now_ms, packet_tag, rtp_stamp}, tuser kind
// m        out  o_m_tvalid/i_m_tready tdata {fill_count, discarded, out_stamp, out_tag},
//                                     tuser {out_valid, status}
// cfg      in   i_cfg_we              i_cfg_index, i_cfg_data
//
// enqueue, clear, restart and unused kinds are accepted, then update the chain and report.
// expire removes its d entries from the chain head one per cycle, then reports.
// a ready dequeue runs the elapsed check, starts the playout scaling, waits for its result,
// forms the target, then does the pops; a dequeue that is not ready reports after the check.
// reset empties the chain at once through the cell valid bits; no clearing pass.
// a result waits in the output register; the final step of an item holds until it is free.
module rtp_jitter_buffer #(
    parameter int CAPACITY = rtpjb_pkg::DEF_CAPACITY,
    parameter int TAG_BITS = rtpjb_pkg::DEF_TAG_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // rtp_stamp[31:0], packet_tag[47:32], now_ms[79:48]
    input  logic [rtpjb_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // kind[2:0]
    input  logic [rtpjb_pkg::IN_USER_W-1:0]  i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // out_tag[15:0], out_stamp[47:16], discarded[52:48], fill_count[57:53], zero fill
    output logic [rtpjb_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // status[2:0], out_valid[3]
    output logic [rtpjb_pkg::OUT_USER_W-1:0] o_m_tuser,
    input  logic                             i_cfg_we,
    input  logic [rtpjb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtpjb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rtpjb_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_ELAP = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DROP = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [STAMP_W-1:0]  r_cmp, n_cmp;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [NOW_W-1:0]    r_now, n_now;
    logic                r_incl, n_incl;
    logic [STAMP_W-1:0]  r_diff, n_diff;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    logic [RATE_W-1:0]   r_rate, n_rate;
    logic                r_muted, n_muted;
    logic                r_started, n_started;
    logic [NOW_W-1:0]    r_start_time, n_start_time;
    logic [STAMP_W-1:0]  r_start_offset, n_start_offset;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic [CNT_W-1:0]    r_disc, n_disc;

    logic                r_out_valid;
    t_status             r_res_status;
    logic                r_res_valid;
    logic [IN_TAG_W-1:0] r_res_tag;
    logic [STAMP_W-1:0]  r_res_stamp;
    logic [COUNT_OUT_W-1:0] r_res_disc;
    logic [COUNT_OUT_W-1:0] r_res_fill;

    logic                w_emit;
    t_status             w_status;
    logic                w_valid;
    logic [IN_TAG_W-1:0] w_otag;
    logic [STAMP_W-1:0]  w_ostamp;
    logic                w_out_free;
    logic                w_div_start;
    logic                w_div_done;
    logic [STAMP_W-1:0]  w_div_ticks;
    logic [NOW_W-1:0]    w_elapsed;
    logic                w_dup;
    logic                w_head_old;
    t_cell_ctl           w_ctl;

    t_entry              w_ent [CAPACITY];
    logic [TAG_BITS-1:0] w_ctag [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry              w_left, w_right;
        logic [TAG_BITS-1:0] w_left_tag, w_right_tag;
        logic                w_left_lt;
        if (g == 0) begin : g_first
            assign w_left     = '0;
            assign w_left_tag = '0;
            assign w_left_lt  = 1'b1;
        end else begin : g_inner_l
            assign w_left     = w_ent[g-1];
            assign w_left_tag = w_ctag[g-1];
            assign w_left_lt  = w_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right     = '0;
            assign w_right_tag = '0;
        end else begin : g_inner_r
            assign w_right     = w_ent[g+1];
            assign w_right_tag = w_ctag[g+1];
        end
        rtpjb_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_new_tag   (r_tag),
            .i_left      (w_left),
            .i_left_tag  (w_left_tag),
            .i_left_lt   (w_left_lt),
            .i_right     (w_right),
            .i_right_tag (w_right_tag),
            .o_entry     (w_ent[g]),
            .o_tag       (w_ctag[g]),
            .o_lt        (w_lt[g]),
            .o_eq        (w_eq[g])
        );
    end

    rtpjb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_diff  (r_diff),
        .i_rate  (r_rate),
        .o_done  (w_div_done),
        .o_ticks (w_div_ticks)
    );

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_elapsed  = r_now - r_start_time;
    assign w_dup      = |w_eq;
    assign w_head_old = w_lt[0] || (r_incl && w_eq[0]);
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_kind         = r_kind;
        n_cmp          = r_cmp;
        n_tag          = r_tag;
        n_now          = r_now;
        n_incl         = r_incl;
        n_diff         = r_diff;
        n_delay        = r_delay;
        n_rate         = r_rate;
        n_muted        = r_muted;
        n_started      = r_started;
        n_start_time   = r_start_time;
        n_start_offset = r_start_offset;
        n_fill         = r_fill;
        n_disc         = r_disc;
        w_ctl.op       = CELL_HOLD;
        w_ctl.stamp    = r_cmp;
        w_emit         = 1'b0;
        w_status       = ST_DONE;
        w_valid        = 1'b0;
        w_otag         = '0;
        w_ostamp       = '0;
        w_div_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind = i_s_tuser;
                    n_cmp  = i_s_tdata[STAMP_W-1:0];
                    n_tag  = TAG_BITS'(i_s_tdata[STAMP_W+IN_TAG_W-1:STAMP_W]);
                    n_now  = i_s_tdata[IN_DATA_W-1:STAMP_W+IN_TAG_W];
                    n_disc = '0;
                    n_incl = 1'b1;
                    unique case (i_s_tuser)
                        KIND_DEQ:    n_state = S_ELAP;
                        KIND_EXPIRE: n_state = S_DROP;
                        default:     n_state = S_EXEC;
                    endcase
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_kind)
                        KIND_ENQ: begin
                            if (r_muted) begin
                                w_status = ST_MUTED;
                            end else begin
                                if (!r_started) begin
                                    n_started      = 1'b1;
                                    n_start_time   = r_now;
                                    n_start_offset = r_cmp;
                                end
                                if (w_dup) begin
                                    w_status = ST_DUP;
                                end else if (r_fill == CNT_W'(CAPACITY)) begin
                                    w_status = ST_FULL;
                                end else begin
                                    w_ctl.op = CELL_INSERT;
                                    n_fill   = r_fill + CNT_W'(1);
                                    w_status = ST_OK;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            w_ctl.op = CELL_CLEAR;
                            n_disc   = r_fill;
                            n_fill   = '0;
                        end
                        KIND_RESTART: begin
                            n_started      = 1'b0;
                            n_start_time   = '0;
                            n_start_offset = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ELAP: begin
                if (!r_started || (w_elapsed < NOW_W'(r_delay))) begin
                    if (w_out_free) begin
                        w_emit   = 1'b1;
                        w_status = ST_NOTREADY;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_diff  = w_elapsed - NOW_W'(r_delay);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_cmp   = w_div_ticks + r_start_offset;
                    n_incl  = 1'b0;
                    n_state = S_DROP;
                end
            end
            S_DROP: begin
                if (w_head_old) begin
                    w_ctl.op = CELL_POP;
                    n_disc   = r_disc + CNT_W'(1);
                    n_fill   = r_fill - CNT_W'(1);
                end else if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (r_kind == KIND_DEQ) begin
                        if (w_ent[0].valid) begin
                            w_ctl.op = CELL_POP;
                            n_fill   = r_fill - CNT_W'(1);
                            w_status = ST_OK;
                            w_valid  = 1'b1;
                            w_otag   = IN_TAG_W'(w_ctag[0]);
                            w_ostamp = w_ent[0].stamp;
                        end else begin
                            w_status = ST_EMPTY;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DELAY: n_delay = i_cfg_data[DELAY_W-1:0];
                CFG_RATE:  n_rate  = i_cfg_data[RATE_W-1:0];
                CFG_MUTED: begin
                    if (i_cfg_data[0] && !r_muted) begin
                        w_ctl.op = CELL_CLEAR;
                        n_fill   = '0;
                    end
                    n_muted = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_delay        <= DELAY_W'(RESET_DELAY);
            r_rate         <= RATE_W'(RESET_RATE);
            r_muted        <= 1'b0;
            r_started      <= 1'b0;
            r_start_time   <= '0;
            r_start_offset <= '0;
            r_fill         <= '0;
            r_disc         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_delay        <= n_delay;
            r_rate         <= n_rate;
            r_muted        <= n_muted;
            r_started      <= n_started;
            r_start_time   <= n_start_time;
            r_start_offset <= n_start_offset;
            r_fill         <= n_fill;
            r_disc         <= n_disc;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_cmp  <= n_cmp;
        r_tag  <= n_tag;
        r_now  <= n_now;
        r_incl <= n_incl;
        r_diff <= n_diff;
        if (w_emit) begin
            r_res_status <= w_status;
            r_res_valid  <= w_valid;
            r_res_tag    <= w_otag;
            r_res_stamp  <= w_ostamp;
            r_res_disc   <= COUNT_OUT_W'(n_disc);
            r_res_fill   <= COUNT_OUT_W'(n_fill);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - IN_TAG_W - STAMP_W - 2*COUNT_OUT_W)'(0),
                         r_res_fill, r_res_disc, r_res_stamp, r_res_tag};
    assign o_m_tuser  = {r_res_valid, r_res_status};

endmodule

@@ tb/sv/rtp_jitter_buffer_tb.sv @@
// testbench for rtp_jitter_buffer: directed, config extremes, backpressure and random stream tests
module rtp_jitter_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtpjb_pkg::*;

    localparam int CAP = DEF_CAPACITY;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic                   out_valid;
        logic [IN_TAG_W-1:0]    out_tag;
        logic [STAMP_W-1:0]     out_stamp;
        logic [COUNT_OUT_W-1:0] discarded;
        logic [COUNT_OUT_W-1:0] fill_count;
    } t_playout_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // rtp_stamp[31:0], packet_tag[47:32], now_ms[79:48]
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    // kind[2:0]
    logic [IN_USER_W-1:0]   i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // out_tag[15:0], out_stamp[47:16], discarded[52:48], fill_count[57:53], zero fill
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    // status[2:0], out_valid[3]
    logic [OUT_USER_W-1:0]  o_m_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor state
    logic [STAMP_W-1:0]  held_stamp [CAP];
    logic [IN_TAG_W-1:0] held_tag [CAP];
    int unsigned         held_count = 0;
    logic                playout_started = 1'b0;
    logic [NOW_W-1:0]    playout_start_ms = '0;
    logic [STAMP_W-1:0]  playout_offset = '0;
    logic [DELAY_W-1:0]  cfg_delay_ms = DELAY_W'(RESET_DELAY);
    logic [RATE_W-1:0]   cfg_rate = RATE_W'(RESET_RATE);
    logic                cfg_muted = 1'b0;

    t_playout_result awaited_results [$];
    int              mismatch_count = 0;
    bit              gaps_on = 1'b1;
    int              rx_stall_left = 0;

    rtp_jitter_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned count_leading(logic [STAMP_W-1:0] lim, bit inclusive);
        int unsigned n = 0;
        while (n < held_count && (held_stamp[n] < lim || (inclusive && held_stamp[n] == lim)))
            n++;
        return n;
    endfunction

    function automatic void drop_leading(int unsigned n);
        if (n > held_count) n = held_count;
        for (int unsigned i = 0; i + n < held_count; i++) begin
            held_stamp[i] = held_stamp[i + n];
            held_tag[i]   = held_tag[i + n];
        end
        held_count -= n;
    endfunction

    function automatic t_playout_result playout_result(logic [KIND_W-1:0] kind,
            logic [STAMP_W-1:0] stamp, logic [IN_TAG_W-1:0] tag, logic [NOW_W-1:0] now_ms);
        t_playout_result r;
        int unsigned     pos;
        logic [31:0]     elapsed;
        logic [31:0]     late_ms;
        logic [63:0]     ticks;
        logic [31:0]     target;
        r.status = ST_DONE;
        r.out_valid = 1'b0;
        r.out_tag = '0;
        r.out_stamp = '0;
        r.discarded = '0;
        case (kind)
            KIND_ENQ: begin
                if (cfg_muted) begin
                    r.status = ST_MUTED;
                end else begin
                    if (!playout_started) begin
                        playout_started  = 1'b1;
                        playout_start_ms = now_ms;
                        playout_offset   = stamp;
                    end
                    pos = count_leading(stamp, 1'b0);
                    if (pos < held_count && held_stamp[pos] == stamp) begin
                        r.status = ST_DUP;
                    end else if (held_count >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int unsigned i = held_count; i > pos; i--) begin
                            held_stamp[i] = held_stamp[i - 1];
                            held_tag[i]   = held_tag[i - 1];
                        end
                        held_stamp[pos] = stamp;
                        held_tag[pos]   = tag;
                        held_count++;
                        r.status = ST_OK;
                    end
                end
            end
            KIND_DEQ: begin
                elapsed = now_ms - playout_start_ms;
                if (!playout_started || elapsed < {16'd0, cfg_delay_ms}) begin
                    r.status = ST_NOTREADY;
                end else begin
                    late_ms = elapsed - {16'd0, cfg_delay_ms};
                    ticks = {32'd0, late_ms} * {44'd0, cfg_rate};
                    ticks = ticks / 64'd1000;
                    target = ticks[31:0] + playout_offset;
                    pos = count_leading(target, 1'b0);
                    r.discarded = COUNT_OUT_W'(pos);
                    drop_leading(pos);
                    if (held_count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.out_valid = 1'b1;
                        r.out_tag   = held_tag[0];
                        r.out_stamp = held_stamp[0];
                        drop_leading(1);
                        r.status = ST_OK;
                    end
                end
            end
            KIND_EXPIRE: begin
                pos = count_leading(stamp, 1'b1);
                r.discarded = COUNT_OUT_W'(pos);
                drop_leading(pos);
            end
            KIND_CLEAR: begin
                r.discarded = COUNT_OUT_W'(held_count);
                drop_leading(held_count);
            end
            KIND_RESTART: begin
                playout_started  = 1'b0;
                playout_start_ms = '0;
                playout_offset   = '0;
            end
            default: ;
        endcase
        r.fill_count = COUNT_OUT_W'(held_count);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_playout();
        t_playout_result want;
        if (awaited_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual tdata 0x%0h tuser 0x%0h",
                     $time, o_m_tdata, o_m_tuser);
            mismatch_count++;
            return;
        end
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(o_m_tuser[2:0]));
        check_field("out_valid", 32'(want.out_valid), 32'(o_m_tuser[3]));
        check_field("out_tag", 32'(want.out_tag), 32'(o_m_tdata[15:0]));
        check_field("out_stamp", want.out_stamp, o_m_tdata[47:16]);
        check_field("discarded", 32'(want.discarded), 32'(o_m_tdata[52:48]));
        check_field("fill_count", 32'(want.fill_count), 32'(o_m_tdata[57:53]));
    endfunction

    // result side: check each transfer, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
            compare_playout();
        if (rx_stall_left > 0) begin
            i_m_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            i_m_tready <= !(gaps_on && $urandom_range(99) < 28);
        end
    end

    task automatic offer_item(logic [KIND_W-1:0] kind, logic [STAMP_W-1:0] stamp,
            logic [IN_TAG_W-1:0] tag, logic [NOW_W-1:0] now_ms);
        if (gaps_on && $urandom_range(99) < 28) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 28);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {now_ms, tag, stamp};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        awaited_results.push_back(playout_result(kind, stamp, tag, now_ms));
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_DELAY: cfg_delay_ms = value[DELAY_W-1:0];
            CFG_RATE:  cfg_rate = value[RATE_W-1:0];
            CFG_MUTED: begin
                if (value[0] && !cfg_muted) drop_leading(held_count);
                cfg_muted = value[0];
            end
            default: ;
        endcase
    endtask

    task automatic apply_config(logic [DELAY_W-1:0] delay_ms, logic [RATE_W-1:0] rate,
            logic mute);
        write_reg(CFG_DELAY, CFG_DATA_W'(delay_ms));
        write_reg(CFG_RATE, CFG_DATA_W'(rate));
        write_reg(CFG_MUTED, CFG_DATA_W'(mute));
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        logic [NOW_W-1:0] t0;
        t0 = 32'h0000_1000;
        offer_item(KIND_DEQ, '0, '0, '0);
        offer_item(3'd5, '1, '1, '1);
        offer_item(3'd6, '0, '0, '0);
        offer_item(3'd7, '1, '1, '1);
        offer_item(KIND_ENQ, 32'd1000, 16'hFFFF, t0);
        offer_item(KIND_ENQ, 32'd1000, 16'h0001, t0 + 1);
        offer_item(KIND_ENQ, 32'hFFFF_FFFF, 16'h0000, t0 + 2);
        offer_item(KIND_ENQ, 32'h0000_0000, 16'hA5A5, t0 + 3);
        offer_item(KIND_ENQ, 32'd2000, 16'h5A5A, t0 + 4);
        offer_item(KIND_ENQ, 32'd1800, 16'h1234, t0 + 5);
        offer_item(KIND_DEQ, '0, '0, t0 + 499);
        offer_item(KIND_DEQ, '0, '0, t0 + 500);
        offer_item(KIND_DEQ, '0, '0, t0 + 600);
        offer_item(KIND_EXPIRE, 32'd1999, '0, '0);
        offer_item(KIND_EXPIRE, 32'd2000, '0, '0);
        offer_item(KIND_RESTART, '1, '1, '1);
        // clock about to wrap at the new start
        offer_item(KIND_ENQ, 32'd5000, 16'h0F0F, 32'hFFFF_FF00);
        offer_item(KIND_DEQ, '0, '0, 32'h0000_0100);
        offer_item(KIND_ENQ, 32'd7000, 16'hF0F0, 32'h0000_0110);
        offer_item(KIND_ENQ, 32'd8000, 16'h8001, 32'h0000_0120);
        offer_item(KIND_CLEAR, '1, '1, '1);
        offer_item(KIND_DEQ, '0, '0, 32'h0000_0300);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        apply_config('0, RATE_W'(1), 1'b0);
        offer_item(KIND_RESTART, '0, '0, '0);
        offer_item(KIND_ENQ, 32'h8000_0000, 16'h0001, 32'h7FFF_FFFF);
        offer_item(KIND_ENQ, 32'h8000_0001, 16'h0002, 32'h8000_0000);
        offer_item(KIND_DEQ, '0, '0, 32'h7FFF_FFFF);
        offer_item(KIND_DEQ, '0, '0, 32'h8000_03E6);
        offer_item(KIND_DEQ, '0, '0, 32'h8000_03E7);
        wait_idle();
        apply_config('1, '1, 1'b0);
        offer_item(KIND_RESTART, '0, '0, '0);
        offer_item(KIND_ENQ, 32'h0000_0010, 16'h00FF, 32'h0000_0000);
        offer_item(KIND_ENQ, 32'hFFFF_0000, 16'hFF00, 32'h0000_0001);
        offer_item(KIND_ENQ, 32'h0000_0020, 16'h0F00, 32'h0000_0002);
        offer_item(KIND_DEQ, '0, '0, 32'h0000_FFFE);
        offer_item(KIND_DEQ, '0, '0, 32'h0000_FFFF);
        offer_item(KIND_DEQ, '0, '0, 32'hFFFF_FFFF);
        wait_idle();
        apply_config(DELAY_W'(RESET_DELAY), RATE_W'(RESET_RATE), 1'b0);
        offer_item(KIND_ENQ, 32'h0000_1000, 16'h1111, 32'h0000_0010);
        offer_item(KIND_ENQ, 32'h0000_2000, 16'h2222, 32'h0000_0020);
        wait_idle();
        // muting drops whatever is held
        apply_config(DELAY_W'(RESET_DELAY), RATE_W'(RESET_RATE), 1'b1);
        offer_item(KIND_ENQ, 32'h0000_3000, 16'h3333, 32'h0000_0030);
        offer_item(KIND_DEQ, '0, '0, 32'h0001_0000);
        wait_idle();
        apply_config(DELAY_W'(RESET_DELAY), RATE_W'(RESET_RATE), 1'b1);
        offer_item(KIND_ENQ, 32'h0000_4000, 16'h4444, 32'h0000_0040);
        wait_idle();
        apply_config(DELAY_W'(RESET_DELAY), RATE_W'(RESET_RATE), 1'b0);
    endtask

    task automatic test_backpressure();
        logic [STAMP_W-1:0] base;
        logic [NOW_W-1:0]   t0;
        base = $urandom;
        t0 = $urandom;
        offer_item(KIND_RESTART, '0, '0, '0);
        offer_item(KIND_CLEAR, '0, '0, '0);
        rx_stall_left = 400;
        // descending stamps so every insert lands at the head, last few find it full
        for (int i = 0; i < 20; i++)
            offer_item(KIND_ENQ, base + STAMP_W'((19 - i) * 160), 16'($urandom), t0 + i);
        wait_idle();
        rx_stall_left = 300;
        for (int i = 0; i < 18; i++)
            offer_item(KIND_DEQ, '0, '0, t0 + 500 + i * 20);
        wait_idle();
    endtask

    task automatic test_random_stream();
        logic [DELAY_W-1:0] dly;
        logic [RATE_W-1:0]  rt;
        logic               mute;
        int unsigned        frame_ms;
        longint unsigned    tpf;
        int unsigned        n_items;
        int unsigned        next_seq;
        int unsigned        pick;
        logic [STAMP_W-1:0] base;
        logic [STAMP_W-1:0] last_stamp;
        logic [STAMP_W-1:0] stamp;
        logic [NOW_W-1:0]   clk_ms;
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            mute = 1'b0;
            dly = DELAY_W'(RESET_DELAY);
            rt = RATE_W'(RESET_RATE);
            case (ph)
                1: begin dly = '0; rt = RATE_W'(48000); end
                2: begin dly = DELAY_W'(60); rt = RATE_W'(1); end
                3: begin dly = '1; rt = '1; end
                4: begin
                    dly = DELAY_W'($urandom_range(0, 300));
                    rt = RATE_W'($urandom_range(1, 100000));
                end
                5: mute = 1'b1;
                6: begin
                    dly = DELAY_W'($urandom);
                    rt = RATE_W'($urandom_range(1, 20'hFFFFF));
                end
                default: ;
            endcase
            apply_config(dly, rt, mute);
            gaps_on = (ph != 4);
            n_items = (ph == 5) ? 40 : 118;
            frame_ms = (dly > 320) ? dly / 8 : $urandom_range(5, 40);
            tpf = (longint'(rt) * frame_ms) / 1000;
            if (tpf == 0) tpf = 1;
            base = (ph == 7) ? 32'hFFFF_FF00 : $urandom;
            clk_ms = (ph == 7) ? 32'hFFFF_F000 : $urandom;
            next_seq = 0;
            last_stamp = base;
            offer_item(KIND_RESTART, $urandom, $urandom, $urandom);
            offer_item(KIND_CLEAR, $urandom, $urandom, $urandom);
            for (int k = 0; k < n_items; k++) begin
                clk_ms += $urandom_range(0, frame_ms);
                pick = $urandom_range(99);
                if (pick < 45) begin
                    if ($urandom_range(9) == 0) begin
                        stamp = last_stamp;
                    end else begin
                        stamp = base + STAMP_W'(tpf * (next_seq + $urandom_range(0, 2)));
                        next_seq++;
                    end
                    last_stamp = stamp;
                    offer_item(KIND_ENQ, stamp, $urandom, clk_ms);
                end else if (pick < 85) begin
                    offer_item(KIND_DEQ, $urandom, $urandom, clk_ms);
                end else if (pick < 89) begin
                    stamp = base + STAMP_W'(tpf * (next_seq - $urandom_range(0, 3)));
                    offer_item(KIND_EXPIRE, stamp, $urandom, $urandom);
                end else if (pick < 91) begin
                    offer_item(KIND_CLEAR, $urandom, $urandom, $urandom);
                end else if (pick < 93) begin
                    offer_item(KIND_RESTART, $urandom, $urandom, $urandom);
                end else if (pick < 98) begin
                    offer_item(KIND_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
                end else begin
                    offer_item(KIND_W'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
                end
            end
        end
        wait_idle();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random_stream();
        wait_idle();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("[rtp_jitter_buffer] OK");
        end else begin
            $display("[rtp_jitter_buffer] ERROR");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("[rtp_jitter_buffer] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rtpjb_pkg.sv
rtl/core/rtpjb_cell.sv
rtl/core/rtpjb_div.sv
rtl/core/rtp_jitter_buffer.sv
tb/sv/rtp_jitter_buffer_tb.sv
